/* rtl/core/dse_pkg.sv */
// Package for the delimited span extractor: sizes, pattern bytes, result word type.
`timescale 1ns / 1ps
`default_nettype none

package dse_pkg;

  // Pattern lengths, offset counter width and the shift window depth.
  localparam int START_LEN    = 67;
  localparam int END_LEN      = 21;
  localparam int OFFSET_WIDTH = 32;
  localparam int PAT_MAX      = 128;
  localparam int WIN_LEN      = (START_LEN > END_LEN) ? START_LEN : END_LEN;
  localparam int FIELD_W      = 32;

  // Bytes of the two patterns as defined, first byte in the top bits.
  localparam int OPEN_DEF_LEN  = 67;
  localparam int CLOSE_DEF_LEN = 21;

  localparam logic [OPEN_DEF_LEN*8-1:0] OPEN_STR = {
    128'h68747470_733a2f2f_77656273_74617469,
    128'h632d7365_612e686f_796f7665_7273652e,
    128'h636f6d2f_67656e73_68696e2f_6576656e,
    128'h742f6532_30313930_39303967_61636861,
    24'h2d7632
  };

  localparam logic [CLOSE_DEF_LEN*8-1:0] CLOSE_STR = {
    128'h2667616d_655f6269_7a3d686b_34655f67,
    40'h6c6f6261_6c
  };

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SPAN = 2'd0,
    KIND_OK   = 2'd1,
    KIND_MISS = 2'd2
  } kind_t;

  // One result word as held in the output queue.
  typedef struct packed {
    kind_t               kind;
    logic [FIELD_W-1:0]  span_start;
    logic [FIELD_W-1:0]  span_length;
    logic [FIELD_W-1:0]  span_count;
    logic                run_last;
  } result_t;

  // Byte i of the start pattern; bytes past the defined text read as zero.
  function automatic logic [7:0] open_pat_byte(input int idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx < OPEN_DEF_LEN) begin
      val = OPEN_STR[(OPEN_DEF_LEN-1-idx)*8 +: 8];
    end
    return val;
  endfunction

  // Byte i of the end pattern; bytes past the defined text read as zero.
  function automatic logic [7:0] close_pat_byte(input int idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx < CLOSE_DEF_LEN) begin
      val = CLOSE_STR[(CLOSE_DEF_LEN-1-idx)*8 +: 8];
    end
    return val;
  endfunction

  // Low bits of a zero-extended value, as carried on a result field.
  function automatic logic [FIELD_W-1:0] to_field(input logic [63:0] val);
    return val[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dse_cell.sv */
// One window cell: holds a byte, passes it on, and compares its incoming byte.
`timescale 1ns / 1ps
`default_nettype none

module dse_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire logic       clear,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] open_byte,
  input  wire logic [7:0] close_byte,
  input  wire logic       open_use,
  input  wire logic       close_use,
  output logic      [7:0] held,
  output logic            open_hit,
  output logic            close_hit
);

  // The compare looks at the byte this cell takes on the current shift.
  assign open_hit  = !open_use  || (byte_in == open_byte);
  assign close_hit = !close_use || (byte_in == close_byte);

  // Shift in the neighbor's byte; the end of a stream empties the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'h00;
    end else if (shift) begin
      held <= clear ? 8'h00 : byte_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dse_out_fifo.sv */
// Four-word result queue taking up to two words a cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none

module dse_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_a,
  input  wire logic             push_b,
  input  wire dse_pkg::result_t word_a,
  input  wire dse_pkg::result_t word_b,
  input  wire logic             pop,
  output dse_pkg::result_t      head,
  output logic                  has_word,
  output logic                  nearly_full
);
  import dse_pkg::*;

  localparam int DEPTH = 4;

  result_t    mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic [2:0] fill_next;
  logic [1:0] push_num;

  assign head        = mem[rd_ptr];
  assign has_word    = (fill != 3'd0);
  // Room for two words must be there before a byte is taken.
  assign nearly_full = (fill > 3'd2);

  assign push_num  = {1'b0, push_a} + {1'b0, push_b};
  assign fill_next = fill + {1'b0, push_num} - {2'b00, pop};

  // Store words; the second word of a byte goes behind the first.
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= word_a;
    end
    if (push_b) begin
      mem[wr_ptr + 2'd1] <= word_b;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_num;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/delimited_span_extractor_unit.sv */
// Top level of the delimited span extractor: window cell chain, span tracking, result queue.
//
//   channel | direction | fields                                        | handshake
//   --------+-----------+-----------------------------------------------+-------------------
//   in      | input     | data_byte, final_byte                         | in_valid/in_stall
//   out     | output    | kind, span_start, span_length, span_count,   | out_valid/out_stall
//           |           | run_last                                      |
//
// One byte is taken per cycle while in_stall is low; the window shifts and both pattern
// compares settle in that cycle, and the results of the byte enter the result queue at the
// same edge. A byte yields zero, one or two result words; each leaves from the queue register.
// The input stalls while the queue cannot take two more words, so stalls on the output
// side reach the input only after the queue has filled.
// Reset (synchronous, active high) empties the window and the queue and starts a new stream;
// the byte marked final does the same for the stream state.
`timescale 1ns / 1ps
`default_nettype none

module delimited_span_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [31:0]      span_start,
  output logic [31:0]      span_length,
  output logic [31:0]      span_count,
  output logic             run_last
);
  import dse_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] OPEN_MIN  = OFFSET_WIDTH'(START_LEN - 1);
  localparam logic [OFFSET_WIDTH-1:0] CLOSE_MIN = OFFSET_WIDTH'(END_LEN - 1);

  logic                    accept;
  logic                    is_final;
  logic [7:0]              chain [WIN_LEN+1];
  logic [WIN_LEN-1:0]      open_hit;
  logic [WIN_LEN-1:0]      close_hit;

  logic                    seeking_end;
  logic [OFFSET_WIDTH-1:0] byte_offset;
  logic [OFFSET_WIDTH-1:0] pending_start;
  logic [FIELD_W-1:0]      found_count;

  logic                    open_ok;
  logic                    close_ok;
  logic [FIELD_W-1:0]      count_inc;
  logic [OFFSET_WIDTH-1:0] span_len;
  logic                    seeking_next;
  logic [OFFSET_WIDTH-1:0] pending_next;
  logic [FIELD_W-1:0]      count_next;
  logic [OFFSET_WIDTH-1:0] offset_next;

  result_t                 span_word;
  result_t                 summary_word;
  result_t                 word_a;
  result_t                 head;
  logic                    push_a;
  logic                    push_b;
  logic                    pop;
  logic                    has_word;
  logic                    nearly_full;

  assign accept   = in_valid && !in_stall;
  assign is_final = final_byte;
  assign chain[0] = data_byte;

  // Row of window cells; cell j holds the byte j places back from the newest.
  for (genvar j = 0; j < WIN_LEN; j++) begin : g_cell
    localparam bit OPEN_USE  = (j < START_LEN);
    localparam bit CLOSE_USE = (j < END_LEN);
    localparam logic [7:0] OPEN_BYTE  = OPEN_USE  ? open_pat_byte(START_LEN - 1 - j) : 8'h00;
    localparam logic [7:0] CLOSE_BYTE = CLOSE_USE ? close_pat_byte(END_LEN - 1 - j) : 8'h00;

    dse_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .clear      (is_final),
      .byte_in    (chain[j]),
      .open_byte  (OPEN_BYTE),
      .close_byte (CLOSE_BYTE),
      .open_use   (OPEN_USE),
      .close_use  (CLOSE_USE),
      .held       (chain[j+1]),
      .open_hit   (open_hit[j]),
      .close_hit  (close_hit[j])
    );
  end

  // Pattern hits, valid only once enough bytes of the stream have arrived.
  assign open_ok  = !seeking_end && (byte_offset >= OPEN_MIN)  && (&open_hit);
  assign close_ok =  seeking_end && (byte_offset >= CLOSE_MIN) && (&close_hit);

  // Span bookkeeping after this byte.
  assign count_inc    = (found_count == '1) ? found_count : found_count + 1'b1;
  assign span_len     = byte_offset - pending_start + 1'b1;
  assign seeking_next = close_ok ? 1'b0 : (open_ok ? 1'b1 : seeking_end);
  assign pending_next = open_ok ? (byte_offset - OPEN_MIN) : pending_start;
  assign count_next   = close_ok ? count_inc : found_count;
  assign offset_next  = (byte_offset == '1) ? byte_offset : byte_offset + 1'b1;

  // Result words of this byte.
  always_comb begin
    span_word.kind        = KIND_SPAN;
    span_word.span_start  = to_field(64'(pending_start));
    span_word.span_length = to_field(64'(span_len));
    span_word.span_count  = count_inc;
    span_word.run_last    = !is_final;

    summary_word.kind        = seeking_next ? KIND_MISS : KIND_OK;
    summary_word.span_start  = seeking_next ? to_field(64'(pending_next)) : '0;
    summary_word.span_length = '0;
    summary_word.span_count  = count_next;
    summary_word.run_last    = 1'b1;
  end

  assign push_a = accept && (close_ok || is_final);
  assign push_b = accept && close_ok && is_final;
  assign word_a = close_ok ? span_word : summary_word;

  // Stream state; the final byte returns it to the start of a new stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeking_end   <= 1'b0;
      byte_offset   <= '0;
      pending_start <= '0;
      found_count   <= '0;
    end else if (accept) begin
      if (is_final) begin
        seeking_end   <= 1'b0;
        byte_offset   <= '0;
        pending_start <= '0;
        found_count   <= '0;
      end else begin
        seeking_end   <= seeking_next;
        byte_offset   <= offset_next;
        pending_start <= pending_next;
        found_count   <= count_next;
      end
    end
  end

  // Result queue between the scan and the output port.
  dse_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_a      (push_a),
    .push_b      (push_b),
    .word_a      (word_a),
    .word_b      (summary_word),
    .pop         (pop),
    .head        (head),
    .has_word    (has_word),
    .nearly_full (nearly_full)
  );

  assign in_stall    = nearly_full;
  assign out_valid   = has_word;
  assign pop         = has_word && !out_stall;
  assign kind        = head.kind;
  assign span_start  = head.span_start;
  assign span_length = head.span_length;
  assign span_count  = head.span_count;
  assign run_last    = head.run_last;

endmodule

`default_nettype wire
